// ===== rtl/tty_pkg.sv =====
package tty_pkg;

    localparam int BUFFER_SIZE_DEF = 16;

    localparam logic [1:0] CMD_RECV = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_XMIT = 2'd2;

    localparam logic [2:0] KIND_LINE  = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_EOF   = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_INTR  = 3'd4;

    localparam logic [2:0] CFG_IFLAG = 3'd0;
    localparam logic [2:0] CFG_LFLAG = 3'd1;
    localparam logic [2:0] CFG_OFLAG = 3'd2;
    localparam logic [2:0] CFG_INTR  = 3'd3;
    localparam logic [2:0] CFG_ERASE = 3'd4;
    localparam logic [2:0] CFG_KILL  = 3'd5;
    localparam logic [2:0] CFG_EOF   = 3'd6;

    localparam logic [1:0] IFLAG_RST = 2'd1;
    localparam logic [4:0] LFLAG_RST = 5'd31;
    localparam logic [1:0] OFLAG_RST = 2'd3;
    localparam logic [7:0] INTR_RST  = 8'd3;
    localparam logic [7:0] ERASE_RST = 8'd8;
    localparam logic [7:0] KILL_RST  = 8'd21;
    localparam logic [7:0] EOF_RST   = 8'd4;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [1:0] {
        BSEL_CONST,
        BSEL_ITEM,
        BSEL_RDATA
    } bsel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ECHO_B,
        S_TX_CR,
        S_INTR,
        S_CARET,
        S_CHAR_C,
        S_INTR_NL,
        S_RUB_BS1,
        S_RUB_SP,
        S_RUB_BS2,
        S_KILL,
        S_COMMIT,
        S_RD_EOF,
        S_RD_DATA,
        S_RD_EMPTY
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       len_dec;
        logic       len_clear;
        logic       line_store;
        logic       ring_push;
        logic       ring_pop;
        logic       eof_set;
        logic       eof_clear;
        logic       commit_run;
        logic       emit;
        logic [2:0] kind;
        bsel_t      bsel;
        logic [7:0] cbyte;
        logic       last;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_recv;
        logic is_read;
        logic is_xmit;
        logic intr_hit;
        logic raw;
        logic erase_hit;
        logic kill_hit;
        logic eof_hit;
        logic nl_hit;
        logic len_zero;
        logic ring_empty;
        logic eof_flag;
        logic commit_done;
        logic out_ready;
        logic echo;
        logic echoe;
        logic echo_nl;
        logic tx_crnl;
    } ctl_stat_t;

endpackage

// ===== rtl/tty_ram.sv =====
module tty_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tty_ctrl.sv =====
module tty_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tty_pkg::ctl_stat_t stat,
    output tty_pkg::ctl_cmd_t  cmd
);

    tty_pkg::state_t state_reg, state_next;
    logic kill_reg, kill_next;
    logic commit_reg, commit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tty_pkg::S_IDLE;
            kill_reg   <= 1'b0;
            commit_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kill_reg   <= kill_next;
            commit_reg <= commit_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        kill_next   = kill_reg;
        commit_next = commit_reg;
        unique case (state_reg)
            tty_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tty_pkg::S_DECODE;
                end
            end
            tty_pkg::S_DECODE:
            begin
                commit_next = 1'b0;
                kill_next   = 1'b0;
                state_next  = tty_pkg::S_IDLE;
                priority if (stat.is_recv)
                begin
                    priority if (stat.intr_hit)
                    begin
                        state_next = tty_pkg::S_INTR;
                    end
                    else if (stat.raw)
                    begin
                        if (stat.echo)
                        begin
                            state_next = tty_pkg::S_ECHO_B;
                        end
                    end
                    else if (stat.erase_hit)
                    begin
                        if (!stat.len_zero)
                        begin
                            priority if (stat.echoe)
                            begin
                                state_next = tty_pkg::S_RUB_BS1;
                            end
                            else if (stat.echo)
                            begin
                                state_next = tty_pkg::S_ECHO_B;
                            end
                            else
                            begin
                                state_next = tty_pkg::S_IDLE;
                            end
                        end
                    end
                    else if (stat.kill_hit)
                    begin
                        if (stat.echoe)
                        begin
                            kill_next  = 1'b1;
                            state_next = tty_pkg::S_KILL;
                        end
                    end
                    else if (stat.eof_hit)
                    begin
                        if (!stat.len_zero)
                        begin
                            state_next = tty_pkg::S_COMMIT;
                        end
                    end
                    else
                    begin
                        commit_next = stat.nl_hit;
                        priority if (stat.echo || (stat.echo_nl && stat.nl_hit))
                        begin
                            state_next = tty_pkg::S_ECHO_B;
                        end
                        else if (stat.nl_hit)
                        begin
                            state_next = tty_pkg::S_COMMIT;
                        end
                        else
                        begin
                            state_next = tty_pkg::S_IDLE;
                        end
                    end
                end
                else if (stat.is_read)
                begin
                    priority if (stat.eof_flag && stat.ring_empty)
                    begin
                        state_next = tty_pkg::S_RD_EOF;
                    end
                    else if (!stat.ring_empty)
                    begin
                        state_next = tty_pkg::S_RD_DATA;
                    end
                    else
                    begin
                        state_next = tty_pkg::S_RD_EMPTY;
                    end
                end
                else if (stat.is_xmit)
                begin
                    if (stat.tx_crnl && stat.nl_hit)
                    begin
                        state_next = tty_pkg::S_TX_CR;
                    end
                    else
                    begin
                        state_next = tty_pkg::S_ECHO_B;
                    end
                end
                else
                begin
                    state_next = tty_pkg::S_IDLE;
                end
            end
            tty_pkg::S_ECHO_B:
            begin
                if (stat.out_ready)
                begin
                    state_next = commit_reg ? tty_pkg::S_COMMIT : tty_pkg::S_IDLE;
                end
            end
            tty_pkg::S_TX_CR:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_ECHO_B;
                end
            end
            tty_pkg::S_INTR:
            begin
                if (stat.out_ready)
                begin
                    state_next = stat.echo ? tty_pkg::S_CARET : tty_pkg::S_IDLE;
                end
            end
            tty_pkg::S_CARET:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_CHAR_C;
                end
            end
            tty_pkg::S_CHAR_C:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_INTR_NL;
                end
            end
            tty_pkg::S_INTR_NL, tty_pkg::S_RD_EOF, tty_pkg::S_RD_DATA, tty_pkg::S_RD_EMPTY:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_IDLE;
                end
            end
            tty_pkg::S_RUB_BS1:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_RUB_SP;
                end
            end
            tty_pkg::S_RUB_SP:
            begin
                if (stat.out_ready)
                begin
                    state_next = tty_pkg::S_RUB_BS2;
                end
            end
            tty_pkg::S_RUB_BS2:
            begin
                if (stat.out_ready)
                begin
                    state_next = kill_reg ? tty_pkg::S_KILL : tty_pkg::S_IDLE;
                end
            end
            tty_pkg::S_KILL:
            begin
                state_next = stat.len_zero ? tty_pkg::S_IDLE : tty_pkg::S_RUB_BS1;
            end
            tty_pkg::S_COMMIT:
            begin
                if (stat.commit_done)
                begin
                    state_next = tty_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tty_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.bsel     = tty_pkg::BSEL_CONST;
        cmd.kind     = tty_pkg::KIND_LINE;
        in_stall     = (state_reg != tty_pkg::S_IDLE);
        unique case (state_reg)
            tty_pkg::S_IDLE:
            begin
                cmd.accept = in_valid;
            end
            tty_pkg::S_DECODE:
            begin
                if (stat.is_recv)
                begin
                    priority if (stat.intr_hit)
                    begin
                        cmd.len_clear = 1'b1;
                    end
                    else if (stat.raw)
                    begin
                        cmd.ring_push = 1'b1;
                    end
                    else if (stat.erase_hit)
                    begin
                        cmd.len_dec = !stat.len_zero;
                    end
                    else if (stat.kill_hit)
                    begin
                        cmd.len_clear = !stat.echoe;
                    end
                    else if (stat.eof_hit)
                    begin
                        cmd.eof_set = stat.len_zero;
                    end
                    else
                    begin
                        cmd.line_store = 1'b1;
                    end
                end
                else if (stat.is_read)
                begin
                    cmd.ring_pop = !(stat.eof_flag && stat.ring_empty) && !stat.ring_empty;
                end
            end
            tty_pkg::S_ECHO_B:
            begin
                cmd.emit = stat.out_ready;
                cmd.bsel = tty_pkg::BSEL_ITEM;
                cmd.last = 1'b1;
            end
            tty_pkg::S_TX_CR:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_CR;
            end
            tty_pkg::S_INTR:
            begin
                cmd.emit = stat.out_ready;
                cmd.kind = tty_pkg::KIND_INTR;
                cmd.last = !stat.echo;
            end
            tty_pkg::S_CARET:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_CARET;
            end
            tty_pkg::S_CHAR_C:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_C;
            end
            tty_pkg::S_INTR_NL:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_NL;
                cmd.last  = 1'b1;
            end
            tty_pkg::S_RUB_BS1:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_BS;
            end
            tty_pkg::S_RUB_SP:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_SP;
            end
            tty_pkg::S_RUB_BS2:
            begin
                cmd.emit  = stat.out_ready;
                cmd.cbyte = tty_pkg::CH_BS;
                cmd.last  = !kill_reg || stat.len_zero;
            end
            tty_pkg::S_KILL:
            begin
                cmd.len_dec = !stat.len_zero;
            end
            tty_pkg::S_COMMIT:
            begin
                cmd.commit_run = 1'b1;
                cmd.len_clear  = stat.commit_done;
            end
            tty_pkg::S_RD_EOF:
            begin
                cmd.emit      = stat.out_ready;
                cmd.eof_clear = stat.out_ready;
                cmd.kind      = tty_pkg::KIND_EOF;
                cmd.last      = 1'b1;
            end
            tty_pkg::S_RD_DATA:
            begin
                cmd.emit = stat.out_ready;
                cmd.kind = tty_pkg::KIND_DATA;
                cmd.bsel = tty_pkg::BSEL_RDATA;
                cmd.last = 1'b1;
            end
            tty_pkg::S_RD_EMPTY:
            begin
                cmd.emit = stat.out_ready;
                cmd.kind = tty_pkg::KIND_EMPTY;
                cmd.last = 1'b1;
            end
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/tty_dp.sv =====
module tty_dp #(
    parameter int BUFFER_SIZE = tty_pkg::BUFFER_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         cmd_in,
    input  logic [7:0]         data_in,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [2:0]         kind,
    output logic [7:0]         byte_out,
    output logic               last,
    input  tty_pkg::ctl_cmd_t  cmd,
    output tty_pkg::ctl_stat_t stat
);

    localparam int RING_AW    = $clog2(BUFFER_SIZE);
    localparam int CNT_W      = $clog2(BUFFER_SIZE + 1);
    localparam int LEN_W      = $clog2(BUFFER_SIZE);
    localparam int LINE_DEPTH = BUFFER_SIZE - 1;
    localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [1:0] iflag_reg;
    logic [4:0] lflag_reg;
    logic [1:0] oflag_reg;
    logic [7:0] intr_char_reg, erase_char_reg, kill_char_reg, eof_char_reg;

    logic [1:0] item_cmd_reg;
    logic [7:0] item_byte_reg, item_byte_next;

    logic [LEN_W-1:0]   line_len_reg, line_len_next;
    logic [LEN_W-1:0]   idx_reg, idx_next;
    logic               pend_reg;
    logic [RING_AW-1:0] head_reg, head_next;
    logic [RING_AW-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]   ring_count_reg, ring_count_next;
    logic               eof_flag_reg, eof_flag_next;

    logic       out_valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] byte_out_reg;
    logic       last_reg;

    logic             line_full, ring_full, issue, push_en, out_ready;
    logic [7:0]       line_rdata, ring_rdata, ring_wdata, beat_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iflag_reg      <= tty_pkg::IFLAG_RST;
            lflag_reg      <= tty_pkg::LFLAG_RST;
            oflag_reg      <= tty_pkg::OFLAG_RST;
            intr_char_reg  <= tty_pkg::INTR_RST;
            erase_char_reg <= tty_pkg::ERASE_RST;
            kill_char_reg  <= tty_pkg::KILL_RST;
            eof_char_reg   <= tty_pkg::EOF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tty_pkg::CFG_IFLAG: iflag_reg      <= cfg_data[1:0];
                tty_pkg::CFG_LFLAG: lflag_reg      <= cfg_data[4:0];
                tty_pkg::CFG_OFLAG: oflag_reg      <= cfg_data[1:0];
                tty_pkg::CFG_INTR:  intr_char_reg  <= cfg_data;
                tty_pkg::CFG_ERASE: erase_char_reg <= cfg_data;
                tty_pkg::CFG_KILL:  kill_char_reg  <= cfg_data;
                tty_pkg::CFG_EOF:   eof_char_reg   <= cfg_data;
                default:            iflag_reg      <= iflag_reg;
            endcase
        end
    end

    // map CR and NL on receive only
    always_comb
    begin
        item_byte_next = data_in;
        if (cmd_in == tty_pkg::CMD_RECV)
        begin
            priority if (data_in == tty_pkg::CH_CR && iflag_reg[0])
            begin
                item_byte_next = tty_pkg::CH_NL;
            end
            else if (data_in == tty_pkg::CH_NL && iflag_reg[1])
            begin
                item_byte_next = tty_pkg::CH_CR;
            end
            else
            begin
                item_byte_next = data_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_cmd_reg  <= cmd_in;
            item_byte_reg <= item_byte_next;
        end
    end

    assign line_full = (line_len_reg == LEN_W'(BUFFER_SIZE - 1));
    assign ring_full = (ring_count_reg == CNT_W'(BUFFER_SIZE));
    assign issue     = cmd.commit_run && (idx_reg != line_len_reg);
    assign push_en   = (cmd.ring_push || (cmd.commit_run && pend_reg)) && !ring_full;
    assign ring_wdata = cmd.commit_run ? line_rdata : item_byte_reg;
    assign out_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        line_len_next = line_len_reg;
        priority if (cmd.len_clear)
        begin
            line_len_next = '0;
        end
        else if (cmd.len_dec)
        begin
            line_len_next = line_len_reg - LEN_W'(1);
        end
        else if (cmd.line_store && !line_full)
        begin
            line_len_next = line_len_reg + LEN_W'(1);
        end
        else
        begin
            line_len_next = line_len_reg;
        end
    end

    always_comb
    begin
        idx_next = '0;
        if (cmd.commit_run)
        begin
            idx_next = issue ? idx_reg + LEN_W'(1) : idx_reg;
        end
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        ring_count_next = ring_count_reg;
        if (push_en)
        begin
            head_next = (head_reg == RING_AW'(BUFFER_SIZE - 1)) ? '0
                                                                : head_reg + RING_AW'(1);
            ring_count_next = ring_count_reg + CNT_W'(1);
        end
        if (cmd.ring_pop)
        begin
            tail_next = (tail_reg == RING_AW'(BUFFER_SIZE - 1)) ? '0
                                                                : tail_reg + RING_AW'(1);
            ring_count_next = ring_count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        eof_flag_next = eof_flag_reg;
        priority if (cmd.eof_set)
        begin
            eof_flag_next = 1'b1;
        end
        else if (cmd.eof_clear)
        begin
            eof_flag_next = 1'b0;
        end
        else
        begin
            eof_flag_next = eof_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg   <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            ring_count_reg <= '0;
            eof_flag_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            line_len_reg   <= line_len_next;
            idx_reg        <= idx_next;
            pend_reg       <= issue;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            ring_count_reg <= ring_count_next;
            eof_flag_reg   <= eof_flag_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.bsel)
            tty_pkg::BSEL_CONST: beat_byte = cmd.cbyte;
            tty_pkg::BSEL_ITEM:  beat_byte = item_byte_reg;
            tty_pkg::BSEL_RDATA: beat_byte = ring_rdata;
            default:             beat_byte = cmd.cbyte;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg     <= cmd.kind;
            byte_out_reg <= beat_byte;
            last_reg     <= cmd.last;
        end
    end

    tty_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (cmd.line_store && !line_full),
        .waddr (line_len_reg[LINE_AW-1:0]),
        .wdata (item_byte_reg),
        .re    (issue),
        .raddr (idx_reg[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    tty_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE)
    ) u_ring_ram (
        .clk   (clk),
        .we    (push_en),
        .waddr (head_reg),
        .wdata (ring_wdata),
        .re    (cmd.ring_pop),
        .raddr (tail_reg),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        stat             = '0;
        stat.is_recv     = (item_cmd_reg == tty_pkg::CMD_RECV);
        stat.is_read     = (item_cmd_reg == tty_pkg::CMD_READ);
        stat.is_xmit     = (item_cmd_reg == tty_pkg::CMD_XMIT);
        stat.intr_hit    = lflag_reg[0] && (item_byte_reg == intr_char_reg);
        stat.raw         = !lflag_reg[1];
        stat.erase_hit   = (item_byte_reg == erase_char_reg);
        stat.kill_hit    = (item_byte_reg == kill_char_reg);
        stat.eof_hit     = (item_byte_reg == eof_char_reg);
        stat.nl_hit      = (item_byte_reg == tty_pkg::CH_NL);
        stat.len_zero    = (line_len_reg == '0);
        stat.ring_empty  = (ring_count_reg == '0);
        stat.eof_flag    = eof_flag_reg;
        stat.commit_done = (idx_reg == line_len_reg) && !pend_reg;
        stat.out_ready   = out_ready;
        stat.echo        = lflag_reg[2];
        stat.echoe       = lflag_reg[3];
        stat.echo_nl     = lflag_reg[4];
        stat.tx_crnl     = oflag_reg[0] && oflag_reg[1];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign byte_out  = byte_out_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= CNT_W'(BUFFER_SIZE))
        else $error("ring count above capacity");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_len_reg <= LEN_W'(BUFFER_SIZE - 1))
        else $error("line length above capacity");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_ready)
        else $error("result loaded over a stalled beat");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ring_pop |=> ring_count_reg == $past(ring_count_reg) - CNT_W'(1))
        else $error("ring pop did not drop count");

    a_commit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit_run && stat.commit_done) |=> line_len_reg == '0)
        else $error("line not cleared after commit");
`endif

endmodule

// ===== rtl/tty_canonical_line_discipline.sv =====
// Terminal line discipline with canonical line editing.
// Input channel: in_valid/in_stall with cmd and data_in. One item is taken at a
// time; in_stall is low only while the block is idle.
// Output channel: out_valid/out_stall with kind, byte_out and last. Each result
// sits in one output register; last marks the final result of an item.
// Configuration: cfg_we writes cfg_data into register cfg_index; the user must do
// so only while idle, as the block itself does not enforce it.
// The first result is loaded into the output register by an output state after
// the decode state, or after the kill state for a kill with echo erase. Each
// result beat has its own output state, which waits while the receiver stalls;
// no new item is taken before the block is back in idle. A line commit moves one
// stored byte per cycle into the ring through the line store's registered read
// port. A kill with echo erase steps kill, backspace, space, backspace per byte.
// Reset clears the line, the ring pointers, the end-of-file mark and the
// output register and loads the default flags and control characters.
// A stalled receiver holds the current beat; the sequencer waits in its output states.
module tty_canonical_line_discipline #(
    parameter int BUFFER_SIZE = tty_pkg::BUFFER_SIZE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] kind,
    output logic [7:0] byte_out,
    output logic       last,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    tty_pkg::ctl_cmd_t  ctl_cmd;
    tty_pkg::ctl_stat_t ctl_stat;

    tty_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    tty_dp #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_in    (cmd),
        .data_in   (data_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .kind      (kind),
        .byte_out  (byte_out),
        .last      (last),
        .cmd       (ctl_cmd),
        .stat      (ctl_stat)
    );

endmodule

// ===== test/tty_line_monitor.sv =====
`timescale 1ns / 1ps

module tty_line_monitor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] data_in,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] kind,
    input  logic [7:0] byte_out,
    input  logic       last,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatch_count,
    output int         beats_due
);

    localparam int DEPTH = tty_pkg::BUFFER_SIZE_DEF;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } tty_beat_t;

    logic [1:0] iflags;
    logic [4:0] lflags;
    logic [1:0] oflags;
    logic [7:0] intr_ch;
    logic [7:0] erase_ch;
    logic [7:0] kill_ch;
    logic [7:0] eof_ch;

    logic [7:0] pending_line [DEPTH - 1];
    int         line_len;
    logic [7:0] ring [DEPTH];
    int         ring_wr;
    int         ring_rd;
    int         ring_fill;
    logic       eof_seen;

    tty_beat_t  expected_beats [$];

    function automatic void emit(input logic [2:0] k, input logic [7:0] v);
        tty_beat_t b;
        b.kind  = k;
        b.value = v;
        b.last  = 1'b0;
        expected_beats.push_back(b);
    endfunction

    function automatic void emit_rubout();
        emit(tty_pkg::KIND_LINE, tty_pkg::CH_BS);
        emit(tty_pkg::KIND_LINE, tty_pkg::CH_SP);
        emit(tty_pkg::KIND_LINE, tty_pkg::CH_BS);
    endfunction

    // drop the byte when the ring is full
    function automatic void ring_put(input logic [7:0] v);
        if (ring_fill < DEPTH)
        begin
            ring[ring_wr] = v;
            ring_wr = (ring_wr + 1) % DEPTH;
            ring_fill++;
        end
    endfunction

    function automatic void flush_line();
        for (int i = 0; i < line_len; i++)
        begin
            ring_put(pending_line[i]);
        end
        line_len = 0;
    endfunction

    function automatic void predict_results(input logic [1:0] op, input logic [7:0] d);
        int         first;
        logic [7:0] b;
        first = expected_beats.size();
        b = d;
        case (op)
            tty_pkg::CMD_RECV:
            begin
                if (b == tty_pkg::CH_CR && iflags[0])
                    b = tty_pkg::CH_NL;
                else if (b == tty_pkg::CH_NL && iflags[1])
                    b = tty_pkg::CH_CR;
                if (lflags[0] && b == intr_ch)
                begin
                    emit(tty_pkg::KIND_INTR, 8'h00);
                    line_len = 0;
                    if (lflags[2])
                    begin
                        emit(tty_pkg::KIND_LINE, tty_pkg::CH_CARET);
                        emit(tty_pkg::KIND_LINE, tty_pkg::CH_C);
                        emit(tty_pkg::KIND_LINE, tty_pkg::CH_NL);
                    end
                end
                else if (!lflags[1])
                begin
                    ring_put(b);
                    if (lflags[2])
                        emit(tty_pkg::KIND_LINE, b);
                end
                else if (b == erase_ch)
                begin
                    if (line_len != 0)
                    begin
                        line_len--;
                        if (lflags[3])
                            emit_rubout();
                        else if (lflags[2])
                            emit(tty_pkg::KIND_LINE, b);
                    end
                end
                else if (b == kill_ch)
                begin
                    while (line_len != 0)
                    begin
                        line_len--;
                        if (lflags[3])
                            emit_rubout();
                    end
                end
                else if (b == eof_ch)
                begin
                    if (line_len != 0)
                        flush_line();
                    else
                        eof_seen = 1'b1;
                end
                else
                begin
                    // hold the byte only while the line has room, echo it anyway
                    if (line_len < DEPTH - 1)
                    begin
                        pending_line[line_len] = b;
                        line_len++;
                    end
                    if (lflags[2] || (lflags[4] && b == tty_pkg::CH_NL))
                        emit(tty_pkg::KIND_LINE, b);
                    if (b == tty_pkg::CH_NL)
                        flush_line();
                end
            end
            tty_pkg::CMD_READ:
            begin
                if (eof_seen && ring_fill == 0)
                begin
                    eof_seen = 1'b0;
                    emit(tty_pkg::KIND_EOF, 8'h00);
                end
                else if (ring_fill != 0)
                begin
                    b = ring[ring_rd];
                    ring_rd = (ring_rd + 1) % DEPTH;
                    ring_fill--;
                    emit(tty_pkg::KIND_DATA, b);
                end
                else
                begin
                    emit(tty_pkg::KIND_EMPTY, 8'h00);
                end
            end
            tty_pkg::CMD_XMIT:
            begin
                if (oflags[0] && oflags[1] && d == tty_pkg::CH_NL)
                    emit(tty_pkg::KIND_LINE, tty_pkg::CH_CR);
                emit(tty_pkg::KIND_LINE, d);
            end
            default:
            begin
            end
        endcase
        if (expected_beats.size() > first)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tty_beat_t want;
        if (!rst_n)
        begin
            iflags    = tty_pkg::IFLAG_RST;
            lflags    = tty_pkg::LFLAG_RST;
            oflags    = tty_pkg::OFLAG_RST;
            intr_ch   = tty_pkg::INTR_RST;
            erase_ch  = tty_pkg::ERASE_RST;
            kill_ch   = tty_pkg::KILL_RST;
            eof_ch    = tty_pkg::EOF_RST;
            line_len  = 0;
            ring_wr   = 0;
            ring_rd   = 0;
            ring_fill = 0;
            eof_seen  = 1'b0;
            expected_beats.delete();
            beats_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tty_pkg::CFG_IFLAG: iflags   = cfg_data[1:0];
                    tty_pkg::CFG_LFLAG: lflags   = cfg_data[4:0];
                    tty_pkg::CFG_OFLAG: oflags   = cfg_data[1:0];
                    tty_pkg::CFG_INTR:  intr_ch  = cfg_data;
                    tty_pkg::CFG_ERASE: erase_ch = cfg_data;
                    tty_pkg::CFG_KILL:  kill_ch  = cfg_data;
                    tty_pkg::CFG_EOF:   eof_ch   = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                predict_results(cmd, data_in);
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected beat: kind %0d, byte_out %02h, last %0d",
                           kind, byte_out, last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        mismatch_count++;
                    end
                    if (byte_out !== want.value)
                    begin
                        $error("byte_out: expected %02h, got %02h", want.value, byte_out);
                        mismatch_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatch_count++;
                    end
                end
            end
            beats_due <= expected_beats.size();
        end
    end

endmodule

// ===== test/tb_tty_canonical_line_discipline.sv =====
`timescale 1ns / 1ps

module tb_tty_canonical_line_discipline;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 64;
    localparam int NUM_REGS      = 7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] cmd = tty_pkg::CMD_RECV;
    logic [7:0] data_in = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] kind;
    logic [7:0] byte_out;
    logic       last;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = tty_pkg::CFG_IFLAG;
    logic [7:0] cfg_data = 8'h00;

    int         mismatch_count;
    int         beats_due;
    int         items_sent = 0;
    int         idle_cycles = 0;
    bit         calm = 1'b0;
    bit         hold_off = 1'b0;
    bit         long_hold_done = 1'b0;
    logic [7:0] cfg_now [NUM_REGS];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tty_canonical_line_discipline dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .byte_out  (byte_out),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tty_line_monitor line_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .data_in        (data_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .byte_out       (byte_out),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[tty_canonical_line_discipline] ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off && !long_hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [1:0] c, input logic [7:0] d);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        data_in  <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // drain all beats, then let any silent commit or kill finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config();
        settle();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= tty_pkg::CFG_IFLAG + 3'(i);
            cfg_data  <= cfg_now[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         len;
        int         pick;
        logic [7:0] ch;

        cfg_now[tty_pkg::CFG_IFLAG] = 8'(tty_pkg::IFLAG_RST);
        cfg_now[tty_pkg::CFG_LFLAG] = 8'(tty_pkg::LFLAG_RST);
        cfg_now[tty_pkg::CFG_OFLAG] = 8'(tty_pkg::OFLAG_RST);
        cfg_now[tty_pkg::CFG_INTR]  = tty_pkg::INTR_RST;
        cfg_now[tty_pkg::CFG_ERASE] = tty_pkg::ERASE_RST;
        cfg_now[tty_pkg::CFG_KILL]  = tty_pkg::KILL_RST;
        cfg_now[tty_pkg::CFG_EOF]   = tty_pkg::EOF_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tty_pkg::CMD_RECV, 8'h68);
        send_item(tty_pkg::CMD_RECV, 8'hFF);
        send_item(tty_pkg::CMD_RECV, tty_pkg::ERASE_RST);
        send_item(tty_pkg::CMD_RECV, 8'h00);
        send_item(tty_pkg::CMD_RECV, tty_pkg::KILL_RST);
        send_item(tty_pkg::CMD_RECV, tty_pkg::ERASE_RST);
        send_item(tty_pkg::CMD_RECV, 8'h78);
        send_item(tty_pkg::CMD_RECV, tty_pkg::CH_CR);
        send_item(tty_pkg::CMD_READ, 8'hFF);
        send_item(tty_pkg::CMD_READ, 8'h00);
        send_item(tty_pkg::CMD_READ, 8'h55);
        send_item(tty_pkg::CMD_RECV, tty_pkg::EOF_RST);
        send_item(tty_pkg::CMD_RECV, 8'h71);
        send_item(tty_pkg::CMD_RECV, tty_pkg::EOF_RST);
        send_item(tty_pkg::CMD_READ, 8'h00);
        send_item(tty_pkg::CMD_READ, 8'h00);
        send_item(tty_pkg::CMD_RECV, 8'h7A);
        send_item(tty_pkg::CMD_RECV, tty_pkg::INTR_RST);
        send_item(tty_pkg::CMD_XMIT, tty_pkg::CH_NL);
        send_item(tty_pkg::CMD_XMIT, 8'h00);
        send_item(tty_pkg::CMD_XMIT, 8'hFF);
        send_item(CMD_NONE, 8'hAA);
        send_item(tty_pkg::CMD_READ, 8'h00);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                end
                1:
                begin
                    cfg_now[tty_pkg::CFG_IFLAG] = 8'h00;
                    cfg_now[tty_pkg::CFG_LFLAG] = 8'h00;
                    cfg_now[tty_pkg::CFG_OFLAG] = 8'h00;
                    cfg_now[tty_pkg::CFG_INTR]  = 8'hFF;
                    cfg_now[tty_pkg::CFG_ERASE] = 8'hFF;
                    cfg_now[tty_pkg::CFG_KILL]  = 8'hFF;
                    cfg_now[tty_pkg::CFG_EOF]   = 8'hFF;
                end
                2:
                begin
                    cfg_now[tty_pkg::CFG_IFLAG] = 8'h03;
                    cfg_now[tty_pkg::CFG_LFLAG] = 8'h1F;
                    cfg_now[tty_pkg::CFG_OFLAG] = 8'h03;
                    cfg_now[tty_pkg::CFG_INTR]  = 8'h00;
                    cfg_now[tty_pkg::CFG_ERASE] = 8'h7F;
                    cfg_now[tty_pkg::CFG_KILL]  = 8'hFF;
                    cfg_now[tty_pkg::CFG_EOF]   = 8'h01;
                end
                default:
                begin
                    cfg_now[tty_pkg::CFG_IFLAG] = 8'($urandom_range(0, 3));
                    cfg_now[tty_pkg::CFG_LFLAG] = 8'($urandom_range(0, 31) |
                                                     ($urandom_range(0, 3) != 0 ? 2 : 0));
                    cfg_now[tty_pkg::CFG_OFLAG] = 8'($urandom_range(0, 3));
                    cfg_now[tty_pkg::CFG_INTR]  = 8'($urandom_range(0, 255));
                    cfg_now[tty_pkg::CFG_ERASE] = 8'($urandom_range(0, 255));
                    cfg_now[tty_pkg::CFG_KILL]  = 8'($urandom_range(0, 255));
                    cfg_now[tty_pkg::CFG_EOF]   = 8'($urandom_range(0, 255));
                end
            endcase
            load_config();
            if (p == 0)
                hold_off = 1'b1;
            if (p == PHASES - 1)
                calm = 1'b1;

            while (items_sent < 23 + (p + 1) * PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        len = $urandom_range(0, 18);
                        for (int i = 0; i < len; i++)
                        begin
                            pick = $urandom_range(0, 29);
                            if (pick == 0)
                                ch = cfg_now[tty_pkg::CFG_ERASE];
                            else if (pick == 1)
                                ch = cfg_now[tty_pkg::CFG_KILL];
                            else if (pick == 2)
                                ch = cfg_now[tty_pkg::CFG_INTR];
                            else if (pick < 6)
                                ch = 8'($urandom_range(0, 255));
                            else
                                ch = 8'($urandom_range(8'h20, 8'h7E));
                            send_item(tty_pkg::CMD_RECV, ch);
                        end
                        case ($urandom_range(0, 4))
                            0, 1: send_item(tty_pkg::CMD_RECV, tty_pkg::CH_NL);
                            2:    send_item(tty_pkg::CMD_RECV, tty_pkg::CH_CR);
                            3:    send_item(tty_pkg::CMD_RECV, cfg_now[tty_pkg::CFG_EOF]);
                            default:
                            begin
                            end
                        endcase
                    end
                    4, 5, 6:
                    begin
                        repeat ($urandom_range(1, 18))
                            send_item(tty_pkg::CMD_READ, 8'($urandom_range(0, 255)));
                    end
                    7:
                    begin
                        repeat ($urandom_range(1, 4))
                            send_item(tty_pkg::CMD_XMIT, ($urandom_range(0, 3) == 0) ?
                                      tty_pkg::CH_NL : 8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    end
                endcase
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("[tty_canonical_line_discipline] OK");
        else
            $display("[tty_canonical_line_discipline] ERROR");
        $finish;
    end

endmodule

// ===== tty_canonical_line_discipline.f =====
rtl/tty_pkg.sv
rtl/tty_ram.sv
rtl/tty_ctrl.sv
rtl/tty_dp.sv
rtl/tty_canonical_line_discipline.sv
test/tty_line_monitor.sv
test/tb_tty_canonical_line_discipline.sv
